[hdl/acq_pkg.sv]
`default_nettype none
package acq_pkg;

	localparam int QUEUE_SLOTS  = 8;
	localparam int CHUNK_FRAMES = 48;

	// one spare slot in the ring holds the chunk being staged
	localparam int RING_SLOTS = QUEUE_SLOTS + 1;
	localparam int PTR_W      = $clog2(RING_SLOTS);
	localparam int HELD_W     = $clog2(QUEUE_SLOTS + 1);
	localparam int FCNT_W     = $clog2(CHUNK_FRAMES + 1);
	localparam int ADDR_W     = $clog2(RING_SLOTS * CHUNK_FRAMES);
	localparam int DEPTH      = RING_SLOTS * CHUNK_FRAMES;

	localparam int SAMPLE_W = 16;
	localparam int WORD_W   = 2 * SAMPLE_W;
	localparam int COUNT_W  = 6;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_DROP    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd3;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} st_t;

	typedef struct packed {
		logic [STATUS_W-1:0]        status;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic [COUNT_W-1:0]         count;
		logic                       last;
	} out_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               last;
	} rd_meta_t;

	typedef struct packed {
		logic s1_free;
		logic s1_empty;
		logic out_free;
	} out_stat_t;

endpackage
`default_nettype wire

[hdl/acq_ram.sv]
`default_nettype none
module acq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[hdl/acq_out.sv]
`default_nettype none
module acq_out (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      issue,
	input  wire acq_pkg::rd_meta_t         meta,
	input  wire logic [acq_pkg::WORD_W-1:0] rdata,
	input  wire logic                      imm_load,
	input  wire acq_pkg::out_item_t        imm_item,
	output acq_pkg::out_stat_t             ostat,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output acq_pkg::out_item_t             out_item
);
	import acq_pkg::*;

	logic      pend_s1_q;
	rd_meta_t  meta_s1;
	logic      out_valid_q;
	out_item_t out_item_q;

	logic out_free;
	logic move;

	assign out_free = !out_valid_q || out_ready;
	// read stage hands its beat over when the output register frees up
	assign move     = pend_s1_q && out_free;

	assign ostat.out_free = out_free;
	assign ostat.s1_free  = !pend_s1_q || move;
	assign ostat.s1_empty = !pend_s1_q;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				pend_s1_q <= 1'b1;
			end else if (move) begin
				pend_s1_q <= 1'b0;
			end
			if (move || imm_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			meta_s1 <= meta;
		end
		if (move) begin
			out_item_q.status <= STAT_OK;
			out_item_q.left   <= rdata[WORD_W-1:SAMPLE_W];
			out_item_q.right  <= rdata[SAMPLE_W-1:0];
			out_item_q.count  <= meta_s1.count;
			out_item_q.last   <= meta_s1.last;
		end else if (imm_load) begin
			out_item_q <= imm_item;
		end
	end

`ifndef SYNTHESIS
	a_imm_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		imm_load |-> (!pend_s1_q && out_free))
		else $error("immediate result collides with a frame beat");
	a_issue_room: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (!pend_s1_q || move))
		else $error("read issued while read stage still holds a beat");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_item_q)))
		else $error("waiting output beat changed");
`endif

endmodule
`default_nettype wire

[hdl/audio_chunk_queue_drop_oldest.sv]
// Queue of up to QUEUE_SLOTS stereo chunks of 1 to CHUNK_FRAMES frames, kept in one
// sample RAM laid out as a ring of QUEUE_SLOTS+1 chunk slots; the spare slot takes the
// chunk being pushed, so a commit only moves pointers and never copies samples. A push
// frame without end is taken and gives no result. A push with chunk_end
// gives one status beat (ok, ok with oldest dropped, or invalid when the chunk ran past
// CHUNK_FRAMES, in which case the queue is left as it was). A pop of an N-frame chunk
// streams N beats, one per cycle when out_ready stays high, behind the registered RAM
// read; the next item is taken once the last frame has left the read stage. A pop on
// an empty queue gives one status beat. The RAM needs no clearing pass after reset.
`default_nettype none
module audio_chunk_queue_drop_oldest (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                func,
	input  wire logic signed [acq_pkg::SAMPLE_W-1:0] left_in,
	input  wire logic signed [acq_pkg::SAMPLE_W-1:0] right_in,
	input  wire logic                                chunk_end,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [acq_pkg::STATUS_W-1:0]             status,
	output logic signed [acq_pkg::SAMPLE_W-1:0]      left_out,
	output logic signed [acq_pkg::SAMPLE_W-1:0]      right_out,
	output logic [acq_pkg::COUNT_W-1:0]              frame_count,
	output logic                                     run_last
);
	import acq_pkg::*;

	st_t               state_q, state_nx;
	logic [PTR_W-1:0]  rd_ptr_q, wr_ptr_q;
	logic [HELD_W-1:0] held_q;
	logic [FCNT_W-1:0] staged_q;
	logic              too_long_q;
	logic [FCNT_W-1:0] idx_q;
	logic [FCNT_W-1:0] slot_frames [RING_SLOTS];

	out_stat_t ostat;
	out_item_t imm_item, out_item;
	rd_meta_t  meta;

	logic              accept, push, commit, pop_empty, pop_start;
	logic              stage_room, too_long_nx, full;
	logic [FCNT_W-1:0] staged_inc, n_frames;
	logic              last_rd, issue, imm_load;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [PTR_W-1:0]  rd_ptr_inc, wr_ptr_inc;
	logic [WORD_W-1:0] rd_word;

	assign rd_ptr_inc = (rd_ptr_q == PTR_W'(RING_SLOTS - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign wr_ptr_inc = (wr_ptr_q == PTR_W'(RING_SLOTS - 1)) ? '0 : wr_ptr_q + 1'b1;

	assign full        = held_q == HELD_W'(QUEUE_SLOTS);
	assign stage_room  = staged_q < FCNT_W'(CHUNK_FRAMES);
	assign staged_inc  = stage_room ? staged_q + 1'b1 : staged_q;
	assign too_long_nx = too_long_q || !stage_room;

	// plain frames go in even while a result waits at the output
	assign in_ready = (state_q == ST_IDLE) && ostat.s1_empty
		&& (ostat.out_free || (func == FUNC_PUSH && !chunk_end));

	assign accept    = in_valid && in_ready;
	assign push      = accept && func == FUNC_PUSH;
	assign commit    = push && chunk_end;
	assign pop_empty = accept && func == FUNC_POP && held_q == '0;
	assign pop_start = accept && func == FUNC_POP && held_q != '0;

	assign we    = push && stage_room;
	assign waddr = ADDR_W'(wr_ptr_q) * ADDR_W'(CHUNK_FRAMES) + ADDR_W'(staged_q);

	assign n_frames = slot_frames[rd_ptr_q];
	assign last_rd  = ({1'b0, idx_q} + 1'b1) >= {1'b0, n_frames};
	assign issue    = (state_q == ST_POP) && ostat.s1_free;
	assign raddr    = ADDR_W'(rd_ptr_q) * ADDR_W'(CHUNK_FRAMES) + ADDR_W'(idx_q);

	assign meta.count = COUNT_W'(n_frames);
	assign meta.last  = last_rd;

	assign imm_load = commit || pop_empty;

	always_comb begin
		imm_item        = '0;
		imm_item.last   = 1'b1;
		imm_item.status = STAT_EMPTY;
		if (commit) begin
			if (too_long_nx) begin
				imm_item.status = STAT_INVALID;
			end else if (full) begin
				imm_item.status = STAT_DROP;
			end else begin
				imm_item.status = STAT_OK;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop_start) begin
					state_nx = ST_POP;
				end
			end
			ST_POP: begin
				if (issue && last_rd) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			held_q     <= '0;
			staged_q   <= '0;
			too_long_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (commit) begin
				staged_q   <= '0;
				too_long_q <= 1'b0;
				if (!too_long_nx) begin
					wr_ptr_q <= wr_ptr_inc;
					// drop the oldest chunk when the queue is already full
					if (full) begin
						rd_ptr_q <= rd_ptr_inc;
					end else begin
						held_q <= held_q + 1'b1;
					end
				end
			end else if (push) begin
				staged_q   <= staged_inc;
				too_long_q <= too_long_nx;
			end
			if (pop_start) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
				if (last_rd) begin
					rd_ptr_q <= rd_ptr_inc;
					held_q   <= held_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && !too_long_nx) begin
			slot_frames[wr_ptr_q] <= staged_inc;
		end
	end

	acq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata({left_in, right_in}),
		.re   (issue),
		.raddr(raddr),
		.rdata(rd_word)
	);

	acq_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (issue),
		.meta     (meta),
		.rdata    (rd_word),
		.imm_load (imm_load),
		.imm_item (imm_item),
		.ostat    (ostat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	assign status      = out_item.status;
	assign left_out    = out_item.left;
	assign right_out   = out_item.right;
	assign frame_count = out_item.count;
	assign run_last    = out_item.last;

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(QUEUE_SLOTS))
		else $error("chunk count beyond queue size");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> (held_q != '0))
		else $error("replaying a chunk from an empty queue");
	a_drop_keeps_full: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !too_long_nx && full) |=> (held_q == HELD_W'(QUEUE_SLOTS)))
		else $error("commit into full queue changed the chunk count");
`endif

endmodule
`default_nettype wire
